// ----- hw/rtl/isl_pkg.sv -----
// Package: shared types, codes and constants of the indexed sequence list.
`timescale 1ns / 1ps

package isl_pkg;

  localparam int unsigned DEF_CAPACITY = 16;
  localparam int unsigned OP_W         = 3;
  localparam int unsigned POS_W        = 5;
  localparam int unsigned WORD_W       = 32;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned COUNT_OUT_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND    = 3'd0,
    OP_DROP_TAIL = 3'd1,
    OP_PREPEND   = 3'd2,
    OP_DROP_HEAD = 3'd3,
    OP_REMOVE_AT = 3'd4,
    OP_INSERT_AT = 3'd5,
    OP_READ_AT   = 3'd6
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_BOUNDS = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic [POS_W-1:0]         position;
    logic signed [WORD_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] read_value;
    logic [STATUS_W-1:0]      status;
    logic [COUNT_OUT_W-1:0]   entry_count;
  } out_item_t;

endpackage

// ----- hw/rtl/isl_stream_if.sv -----
// Interface: valid/ready stream channel carrying one payload beat.
`timescale 1ns / 1ps

interface isl_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/indexed_sequence_list.sv -----
// Top level: indexed sequence list with a row of shifting entry cells.
//
//  channel | dir | payload                               | beat taken when
//  in_i    | in  | op, position, value                   | valid & ready
//  out_o   | out | read_value, status, entry_count       | valid & ready
//
// One operation per cycle while out_o does not stall: a beat lands in the input
// register, is then applied to the entry row (each cell compares its index with
// the slot and shifts) and the result is registered.
// Reset clears the held count and both valid flags; entries are not cleared.
// A stalled result holds; the input register still drains when out_o frees.
`timescale 1ns / 1ps

module indexed_sequence_list #(
  parameter int unsigned CAPACITY = isl_pkg::DEF_CAPACITY
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  isl_stream_if.sink          in_i,
  isl_stream_if.source        out_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = ((CNT_W > isl_pkg::POS_W) ? CNT_W : isl_pkg::POS_W) + 1;
  localparam int unsigned W     = isl_pkg::WORD_W;

  // input register
  logic              s1_valid_q;
  isl_pkg::in_item_t s1_q;
  // result register
  logic               out_valid_q;
  isl_pkg::out_item_t res_q, res_d;
  // state
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic signed [W-1:0] ent_q [CAPACITY];

  logic adv;
  logic in_beat;
  logic in_ready;

  assign adv      = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_ready = !s1_valid_q || adv;
  assign in_i.ready = in_ready;
  assign in_beat    = in_i.valid && in_ready;

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
        cnt_q       <= cnt_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      s1_q <= in_i.payload;
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  // operation decode
  logic [CMP_W-1:0]    pos_w, cnt_w, slot;
  logic                do_ins, do_rem, full, empty, pos_bad;
  logic signed [W-1:0] rd_sel;
  isl_pkg::status_e    st;
  logic signed [W-1:0] rd;

  always_comb begin
    rd_sel = '0;
    for (int i = 0; i < int'(CAPACITY); i++) begin
      if (CMP_W'(i) == pos_w - CMP_W'(1)) begin
        rd_sel = ent_q[i];
      end
    end
  end

  always_comb begin
    pos_w   = CMP_W'(s1_q.position);
    cnt_w   = CMP_W'(cnt_q);
    full    = (cnt_q == CNT_W'(CAPACITY));
    empty   = (cnt_q == '0);
    pos_bad = (pos_w == '0) || (pos_w > cnt_w);
    slot    = '0;
    do_ins  = 1'b0;
    do_rem  = 1'b0;
    st      = isl_pkg::ST_OK;
    rd      = '0;
    cnt_d   = cnt_q;
    case (isl_pkg::op_e'(s1_q.op))
      isl_pkg::OP_APPEND: begin
        if (full) st = isl_pkg::ST_FULL;
        else begin
          do_ins = 1'b1;
          slot   = cnt_w;
        end
      end
      isl_pkg::OP_DROP_TAIL: begin
        if (empty) st = isl_pkg::ST_BOUNDS;
        else cnt_d = cnt_q - CNT_W'(1);
      end
      isl_pkg::OP_PREPEND: begin
        if (full) st = isl_pkg::ST_FULL;
        else do_ins = 1'b1;
      end
      isl_pkg::OP_DROP_HEAD: begin
        if (empty) st = isl_pkg::ST_BOUNDS;
        else do_rem = 1'b1;
      end
      isl_pkg::OP_REMOVE_AT: begin
        if (pos_bad) st = isl_pkg::ST_BOUNDS;
        else begin
          do_rem = 1'b1;
          slot   = pos_w - CMP_W'(1);
        end
      end
      isl_pkg::OP_INSERT_AT: begin
        // insert may land one past the tail
        if ((pos_w == '0) || (pos_w > cnt_w + CMP_W'(1))) st = isl_pkg::ST_BOUNDS;
        else if (full) st = isl_pkg::ST_FULL;
        else begin
          do_ins = 1'b1;
          slot   = pos_w - CMP_W'(1);
        end
      end
      isl_pkg::OP_READ_AT: begin
        if (pos_bad) begin
          st = isl_pkg::ST_BOUNDS;
          rd = '1;
        end else begin
          rd = rd_sel;
        end
      end
      default: ;
    endcase
    if (do_ins) cnt_d = cnt_q + CNT_W'(1);
    if (do_rem) cnt_d = cnt_q - CNT_W'(1);

    res_d.read_value  = rd;
    res_d.status      = st;
    res_d.entry_count = isl_pkg::COUNT_OUT_W'(cnt_d);
  end

  // row of entry cells: each compares its index with the slot and shifts
  for (genvar g = 0; g < int'(CAPACITY); g++) begin : g_cell
    logic signed [W-1:0] from_left, from_right;
    if (g == 0) begin : g_first
      assign from_left = s1_q.value;
    end else begin : g_mid
      assign from_left = ent_q[g-1];
    end
    if (g == int'(CAPACITY) - 1) begin : g_last
      assign from_right = ent_q[g];
    end else begin : g_inner
      assign from_right = ent_q[g+1];
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (do_ins) begin
          if (CMP_W'(g) == slot) ent_q[g] <= s1_q.value;
          else if (CMP_W'(g) > slot) ent_q[g] <= from_left;
        end else if (do_rem && (CMP_W'(g) >= slot)) begin
          ent_q[g] <= from_right;
        end
      end
    end
  end

  // checks
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("held count beyond capacity");

  a_count_still: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(cnt_q))
    else $error("held count moved without an operation");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (res_q.status == isl_pkg::ST_FULL)) |->
      (res_q.entry_count == isl_pkg::COUNT_OUT_W'(CAPACITY)))
    else $error("full status reported below capacity");

endmodule

// ----- tb/indexed_sequence_list_tb.sv -----
// Testbench: directed table plus random operations checked against a list predictor.
`timescale 1ns / 1ps

module indexed_sequence_list_tb;

  localparam int unsigned CAPACITY       = isl_pkg::DEF_CAPACITY;
  localparam int          DIR_N          = 25;
  localparam int          RAND_ITEMS     = 1425;
  localparam int          PHASE_LEN      = 40;
  localparam int          GAP_PCT        = 7;
  localparam int          DRAIN_CYCLES   = 8;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam logic [isl_pkg::OP_W-1:0] OP_UNUSED = 3'd7;

  localparam int MODE_GROW   = 0;
  localparam int MODE_MIXED  = 1;
  localparam int MODE_SHRINK = 2;

  typedef struct packed {
    logic [isl_pkg::OP_W-1:0]        op;
    logic [isl_pkg::POS_W-1:0]       pos;
    logic [isl_pkg::WORD_W-1:0]      value;
    logic                            typed;
    logic [isl_pkg::WORD_W-1:0]      rd;
    logic [isl_pkg::STATUS_W-1:0]    st;
    logic [isl_pkg::COUNT_OUT_W-1:0] cnt;
  } dir_row_t;

  // typed rows carry their own expectation; the others use the predictor
  dir_row_t dir_rows [DIR_N] = '{
    '{isl_pkg::OP_READ_AT,   5'd1,  32'h0,        1'b1, 32'hFFFFFFFF, isl_pkg::ST_BOUNDS, 5'd0},
    '{isl_pkg::OP_DROP_TAIL, 5'd0,  32'h0,        1'b1, 32'h0,        isl_pkg::ST_BOUNDS, 5'd0},
    '{isl_pkg::OP_DROP_HEAD, 5'd0,  32'h0,        1'b1, 32'h0,        isl_pkg::ST_BOUNDS, 5'd0},
    '{isl_pkg::OP_REMOVE_AT, 5'd1,  32'h0,        1'b1, 32'h0,        isl_pkg::ST_BOUNDS, 5'd0},
    '{isl_pkg::OP_INSERT_AT, 5'd0,  32'h5,        1'b1, 32'h0,        isl_pkg::ST_BOUNDS, 5'd0},
    '{isl_pkg::OP_INSERT_AT, 5'd2,  32'h5,        1'b1, 32'h0,        isl_pkg::ST_BOUNDS, 5'd0},
    '{isl_pkg::OP_PREPEND,   5'd0,  32'h7FFFFFFF, 1'b1, 32'h0,        isl_pkg::ST_OK,     5'd1},
    '{isl_pkg::OP_READ_AT,   5'd1,  32'h0,        1'b1, 32'h7FFFFFFF, isl_pkg::ST_OK,     5'd1},
    '{isl_pkg::OP_APPEND,    5'd0,  32'h80000000, 1'b1, 32'h0,        isl_pkg::ST_OK,     5'd2},
    '{isl_pkg::OP_READ_AT,   5'd2,  32'h0,        1'b1, 32'h80000000, isl_pkg::ST_OK,     5'd2},
    '{isl_pkg::OP_INSERT_AT, 5'd3,  32'hFFFFFFFF, 1'b1, 32'h0,        isl_pkg::ST_OK,     5'd3},
    '{isl_pkg::OP_INSERT_AT, 5'd1,  32'h0,        1'b1, 32'h0,        isl_pkg::ST_OK,     5'd4},
    '{isl_pkg::OP_READ_AT,   5'd0,  32'h0,        1'b1, 32'hFFFFFFFF, isl_pkg::ST_BOUNDS, 5'd4},
    '{isl_pkg::OP_READ_AT,   5'd5,  32'h0,        1'b1, 32'hFFFFFFFF, isl_pkg::ST_BOUNDS, 5'd4},
    '{isl_pkg::OP_READ_AT,   5'd31, 32'h0,        1'b1, 32'hFFFFFFFF, isl_pkg::ST_BOUNDS, 5'd4},
    '{isl_pkg::OP_INSERT_AT, 5'd2,  32'h5A5A5A5A, 1'b0, 32'h0,        isl_pkg::ST_OK,     5'd0},
    '{isl_pkg::OP_REMOVE_AT, 5'd3,  32'h0,        1'b0, 32'h0,        isl_pkg::ST_OK,     5'd0},
    '{isl_pkg::OP_READ_AT,   5'd3,  32'h0,        1'b0, 32'h0,        isl_pkg::ST_OK,     5'd0},
    '{isl_pkg::OP_REMOVE_AT, 5'd5,  32'h0,        1'b0, 32'h0,        isl_pkg::ST_OK,     5'd0},
    '{isl_pkg::OP_DROP_HEAD, 5'd0,  32'h0,        1'b0, 32'h0,        isl_pkg::ST_OK,     5'd0},
    '{isl_pkg::OP_DROP_TAIL, 5'd0,  32'h0,        1'b0, 32'h0,        isl_pkg::ST_OK,     5'd0},
    '{OP_UNUSED,             5'd31, 32'hFFFFFFFF, 1'b0, 32'h0,        isl_pkg::ST_OK,     5'd0},
    '{isl_pkg::OP_READ_AT,   5'd2,  32'h0,        1'b0, 32'h0,        isl_pkg::ST_OK,     5'd0},
    '{isl_pkg::OP_REMOVE_AT, 5'd1,  32'h0,        1'b0, 32'h0,        isl_pkg::ST_OK,     5'd0},
    '{isl_pkg::OP_REMOVE_AT, 5'd1,  32'h0,        1'b0, 32'h0,        isl_pkg::ST_OK,     5'd0}
  };

  logic clk = 1'b0;
  logic rst_n;

  isl_stream_if #(.T(isl_pkg::in_item_t))  in_if ();
  isl_stream_if #(.T(isl_pkg::out_item_t)) out_if ();

  indexed_sequence_list #(.CAPACITY(CAPACITY)) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #4 clk = ~clk;

  // predictor state
  logic signed [isl_pkg::WORD_W-1:0] list_words [CAPACITY];
  int unsigned                       list_len;

  // expected results in flight: the sender fills, the checker drains
  isl_pkg::out_item_t exp_ring [8];
  int unsigned        exp_in       = 0;
  int unsigned        exp_out      = 0;
  bit                 no_gaps;
  int                 fail_count   = 0;
  int                 ops_sent;
  int                 results_seen = 0;
  int                 full_hits    = 0;
  int                 bounds_hits  = 0;
  int                 idle_cycles;

  function automatic void open_slot(int unsigned k, logic signed [isl_pkg::WORD_W-1:0] word);
    for (int unsigned i = list_len; i > k; i--) list_words[i] = list_words[i-1];
    list_words[k] = word;
    list_len++;
  endfunction

  function automatic void close_slot(int unsigned k);
    for (int unsigned i = k; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
    list_len--;
  endfunction

  function automatic isl_pkg::out_item_t apply_list_op(isl_pkg::in_item_t it);
    isl_pkg::out_item_t r;
    int unsigned        p;
    r = '0;
    p = it.position;
    case (it.op)
      isl_pkg::OP_APPEND: begin
        if (list_len >= CAPACITY) r.status = isl_pkg::ST_FULL;
        else open_slot(list_len, it.value);
      end
      isl_pkg::OP_DROP_TAIL: begin
        if (list_len == 0) r.status = isl_pkg::ST_BOUNDS;
        else list_len--;
      end
      isl_pkg::OP_PREPEND: begin
        if (list_len >= CAPACITY) r.status = isl_pkg::ST_FULL;
        else open_slot(0, it.value);
      end
      isl_pkg::OP_DROP_HEAD: begin
        if (list_len == 0) r.status = isl_pkg::ST_BOUNDS;
        else close_slot(0);
      end
      isl_pkg::OP_REMOVE_AT: begin
        if (p == 0 || p > list_len) r.status = isl_pkg::ST_BOUNDS;
        else close_slot(p - 1);
      end
      isl_pkg::OP_INSERT_AT: begin
        // position is checked before fullness
        if (p == 0 || p > list_len + 1) r.status = isl_pkg::ST_BOUNDS;
        else if (list_len >= CAPACITY) r.status = isl_pkg::ST_FULL;
        else open_slot(p - 1, it.value);
      end
      isl_pkg::OP_READ_AT: begin
        if (p == 0 || p > list_len) begin
          r.status     = isl_pkg::ST_BOUNDS;
          r.read_value = '1;
        end else begin
          r.read_value = list_words[p-1];
        end
      end
      default: ;
    endcase
    r.entry_count = isl_pkg::COUNT_OUT_W'(list_len);
    return r;
  endfunction

  // mostly in-range positions; the rest anywhere in the 5-bit field
  function automatic isl_pkg::in_item_t random_list_op(int mode);
    isl_pkg::in_item_t it;
    int unsigned       r;
    int unsigned       top;
    r = $urandom_range(99);
    case (mode)
      MODE_GROW: begin
        if      (r < 30) it.op = isl_pkg::OP_APPEND;
        else if (r < 55) it.op = isl_pkg::OP_PREPEND;
        else if (r < 80) it.op = isl_pkg::OP_INSERT_AT;
        else if (r < 88) it.op = isl_pkg::OP_READ_AT;
        else if (r < 92) it.op = isl_pkg::OP_REMOVE_AT;
        else if (r < 95) it.op = isl_pkg::OP_DROP_TAIL;
        else if (r < 98) it.op = isl_pkg::OP_DROP_HEAD;
        else             it.op = OP_UNUSED;
      end
      MODE_SHRINK: begin
        if      (r < 20) it.op = isl_pkg::OP_DROP_TAIL;
        else if (r < 40) it.op = isl_pkg::OP_DROP_HEAD;
        else if (r < 65) it.op = isl_pkg::OP_REMOVE_AT;
        else if (r < 78) it.op = isl_pkg::OP_READ_AT;
        else if (r < 84) it.op = isl_pkg::OP_APPEND;
        else if (r < 90) it.op = isl_pkg::OP_PREPEND;
        else if (r < 98) it.op = isl_pkg::OP_INSERT_AT;
        else             it.op = OP_UNUSED;
      end
      default: begin
        if (r < 98) it.op = isl_pkg::OP_W'($urandom_range(isl_pkg::OP_READ_AT));
        else        it.op = OP_UNUSED;
      end
    endcase
    top = (it.op == isl_pkg::OP_INSERT_AT) ? list_len + 1 : (list_len == 0 ? 1 : list_len);
    if ($urandom_range(99) < 85) it.position = isl_pkg::POS_W'($urandom_range(top, 1));
    else                         it.position = isl_pkg::POS_W'($urandom_range(31));
    if ($urandom_range(99) < 10) begin
      case ($urandom_range(4))
        0:       it.value = 32'h0;
        1:       it.value = 32'h1;
        2:       it.value = 32'hFFFFFFFF;
        3:       it.value = 32'h7FFFFFFF;
        default: it.value = 32'h80000000;
      endcase
    end else begin
      it.value = $urandom;
    end
    return it;
  endfunction

  task automatic send_op(isl_pkg::in_item_t it, bit typed, isl_pkg::out_item_t typed_exp);
    isl_pkg::out_item_t predicted;
    while (!no_gaps && $urandom_range(99) < GAP_PCT) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= it;
    do @(posedge clk); while (!in_if.ready);
    predicted = apply_list_op(it);
    exp_ring[exp_in[2:0]] = typed ? typed_exp : predicted;
    exp_in++;
    ops_sent++;
  endtask

  // result side: random stalls and the field-by-field check
  always @(posedge clk) begin
    isl_pkg::out_item_t want;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (out_if.payload.status == isl_pkg::ST_FULL)   full_hits++;
        if (out_if.payload.status == isl_pkg::ST_BOUNDS) bounds_hits++;
        if (exp_in == exp_out) begin
          $error("result beat with nothing expected: %p", out_if.payload);
          fail_count++;
        end else begin
          want = exp_ring[exp_out[2:0]];
          exp_out++;
          if (out_if.payload.read_value !== want.read_value) begin
            $error("read_value: expected %0d, got %0d",
                   want.read_value, out_if.payload.read_value);
            fail_count++;
          end
          if (out_if.payload.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_if.payload.status);
            fail_count++;
          end
          if (out_if.payload.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d",
                   want.entry_count, out_if.payload.entry_count);
            fail_count++;
          end
        end
      end
      out_if.ready <= no_gaps || ($urandom_range(99) >= GAP_PCT);
    end else begin
      out_if.ready <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d results pending",
                 idle_cycles, exp_in - exp_out);
        $display("indexed_sequence_list test failed");
        $finish;
      end
    end else begin
      idle_cycles <= 0;
    end
  end

  initial begin
    isl_pkg::in_item_t  it;
    isl_pkg::out_item_t typed_exp;
    rst_n         = 1'b0;
    in_if.valid   = 1'b0;
    in_if.payload = '0;
    no_gaps       = 1'b0;
    ops_sent      = 0;
    list_len      = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      it.op                 = dir_rows[i].op;
      it.position           = dir_rows[i].pos;
      it.value              = dir_rows[i].value;
      typed_exp.read_value  = dir_rows[i].rd;
      typed_exp.status      = dir_rows[i].st;
      typed_exp.entry_count = dir_rows[i].cnt;
      send_op(it, dir_rows[i].typed, typed_exp);
    end

    for (int i = 0; i < RAND_ITEMS; i++) begin
      no_gaps = (i >= 600 && i < 900);
      if (i == 300) begin
        // hold off until the list has answered everything sent so far
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (exp_in != exp_out) @(posedge clk);
      end
      send_op(random_list_op((i / PHASE_LEN) % 3), 1'b0, '0);
    end
    no_gaps = 1'b0;
    in_if.valid <= 1'b0;

    while (exp_in != exp_out) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d list operations driven (%0d from the table), %0d results checked",
             ops_sent, DIR_N, results_seen);
    $display("grow/shrink phases hit full %0d times and out-of-bounds or empty %0d times",
             full_hits, bounds_hits);
    if (fail_count == 0) begin
      $display("indexed_sequence_list test passed");
    end else begin
      $display("indexed_sequence_list test failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/isl_pkg.sv
hw/rtl/isl_stream_if.sv
hw/rtl/indexed_sequence_list.sv
tb/indexed_sequence_list_tb.sv
